// ===== rtl/ngte_pkg.sv =====
// Shared constants, result item type and hour conversion for the GLL time extractor.
package ngte_pkg;

  // Commas that precede the UTC time field.
  localparam int TIME_FIELD_COMMAS = 5;
  localparam int CAPTURE_STAGE_I   = TIME_FIELD_COMMAS + 1;
  localparam int STAGE_W           = $clog2(CAPTURE_STAGE_I + 1);

  // Bytes in the hhmmss field.
  localparam int TIME_CHARS = 6;
  localparam int COUNT_W    = $clog2(TIME_CHARS + 1);

  localparam int CHAR_W   = 8;
  localparam int OFFSET_W = 5;

  localparam logic [STAGE_W-1:0] STAGE_IDLE    = STAGE_W'(0);
  localparam logic [STAGE_W-1:0] STAGE_FIRST   = STAGE_W'(1);
  localparam logic [STAGE_W-1:0] STAGE_LAST    = STAGE_W'(TIME_FIELD_COMMAS);
  localparam logic [STAGE_W-1:0] STAGE_CAPTURE = STAGE_W'(CAPTURE_STAGE_I);

  localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(TIME_CHARS - 1);
  localparam logic [COUNT_W-1:0] COUNT_HOUR_ONES = COUNT_W'(1);

  localparam logic [CHAR_W-1:0] CHAR_L     = 8'h4C;
  localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'd49;
  localparam logic [CHAR_W-1:0] CHAR_TWO   = 8'd50;
  localparam logic [CHAR_W-1:0] CHAR_THREE = 8'd51;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

  localparam logic [OFFSET_W-1:0] HOUR_OFFSET_RESET = 5'd8;

  // Reciprocal of 24 scaled by 2^12; exact floor for every 8-bit value.
  localparam logic [7:0] RECIP_24   = 8'd171;
  localparam int         RECIP_SHIFT = 12;

  // One result item.
  typedef struct packed {
    logic [CHAR_W-1:0] hour_tens_char;
    logic [CHAR_W-1:0] hour_ones_char;
    logic [CHAR_W-1:0] minute_tens_char;
    logic [CHAR_W-1:0] minute_ones_char;
    logic [CHAR_W-1:0] second_tens_char;
    logic [CHAR_W-1:0] second_ones_char;
  } time_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] tens;
    logic [CHAR_W-1:0] ones;
  } hour_chars_t;

  // Reduce an 8-bit hour sum modulo 24 and split it into two ASCII digits.
  function automatic hour_chars_t hour_chars(input logic [7:0] sum);
    logic [15:0] prod;
    logic [3:0]  quot;
    logic [7:0]  rem;
    hour_chars_t res;
    prod = 16'(sum) * 16'(RECIP_24);
    quot = prod[RECIP_SHIFT +: 4];
    rem  = sum - 8'(quot) * 8'd24;
    if (rem >= 8'd20) begin
      res.tens = CHAR_TWO;
      res.ones = CHAR_ZERO + (rem - 8'd20);
    end else if (rem >= 8'd10) begin
      res.tens = CHAR_ONE;
      res.ones = CHAR_ZERO + (rem - 8'd10);
    end else begin
      res.tens = CHAR_ZERO;
      res.ones = CHAR_ZERO + rem;
    end
    return res;
  endfunction

endpackage

// ===== rtl/ngte_if.sv =====
// Valid/ready channel interfaces for received bytes and for time result items.
interface ngte_byte_if;
  logic                          valid;
  logic                          ready;
  logic [ngte_pkg::CHAR_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ngte_time_if;
  logic                  valid;
  logic                  ready;
  ngte_pkg::time_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/nmea_gll_time_extract_local.sv =====
// Top level: scans GLL bytes, captures hhmmss and emits local time as ASCII.
//
//  channel     | direction | handshake          | payload
//  ------------+-----------+--------------------+------------------------------
//  byte_in     | sink      | valid / ready      | rx_byte[7:0]
//  time_out    | source    | valid / ready      | six ASCII chars (time_item_t)
//  cfg         | write     | cfg_wr_en          | cfg_wr_data[4:0] hour offset
//
// One byte is taken per cycle while byte_in is not stalled. After the sixth
// time byte is taken, a result item passes through the hour-sum register, then
// the modulo 24 reduction into the output register, and appears on time_out.
// rst (synchronous) idles the scan, empties both result registers, sets offset 8.
// The hour-sum register acts as a skid stage: byte_in stalls only when it and
// the output register are both full and time_out.ready is low.
module nmea_gll_time_extract_local (
  input  logic                           clk,
  input  logic                           rst,
  ngte_byte_if.sink                      byte_in,
  ngte_time_if.source                    time_out,
  input  logic                           cfg_wr_en,
  input  logic [ngte_pkg::OFFSET_W-1:0]  cfg_wr_data
);

  logic [ngte_pkg::OFFSET_W-1:0] hour_offset;
  logic [ngte_pkg::STAGE_W-1:0]  scan_stage;
  logic [ngte_pkg::STAGE_W-1:0]  scan_stage_next;
  logic [ngte_pkg::COUNT_W-1:0]  capture_count;
  logic [ngte_pkg::COUNT_W-1:0]  capture_count_next;
  logic [ngte_pkg::CHAR_W-1:0]   time_digits [0:ngte_pkg::TIME_CHARS-2];
  logic [7:0]                    hour_base;

  logic                          mid_valid;
  logic [7:0]                    mid_sum;
  logic [ngte_pkg::CHAR_W-1:0]   mid_min_tens;
  logic [ngte_pkg::CHAR_W-1:0]   mid_min_ones;
  logic [ngte_pkg::CHAR_W-1:0]   mid_sec_tens;
  logic [ngte_pkg::CHAR_W-1:0]   mid_sec_ones;

  logic                          out_valid;
  ngte_pkg::time_item_t          out_item;

  logic                          accept;
  logic                          is_l;
  logic                          is_comma;
  logic                          capturing;
  logic                          emit;
  logic                          mid_adv;
  logic [7:0]                    base_next;
  ngte_pkg::hour_chars_t         hour_res;

  // Handshake control
  assign mid_adv          = mid_valid && (!out_valid || time_out.ready);
  assign byte_in.ready    = !mid_valid || mid_adv;
  assign accept           = byte_in.valid && byte_in.ready;
  assign time_out.valid   = out_valid;
  assign time_out.item    = out_item;

  // Decode the incoming byte
  assign is_l      = (byte_in.rx_byte == ngte_pkg::CHAR_L);
  assign is_comma  = (byte_in.rx_byte == ngte_pkg::CHAR_COMMA);
  assign capturing = (scan_stage == ngte_pkg::STAGE_CAPTURE);
  assign emit      = accept && !is_l && capturing && (capture_count == ngte_pkg::COUNT_LAST);

  // Advance the comma scan and the capture count
  always_comb begin
    scan_stage_next    = scan_stage;
    capture_count_next = capture_count;
    if (is_l) begin
      scan_stage_next = ngte_pkg::STAGE_FIRST;
    end else if (scan_stage >= ngte_pkg::STAGE_FIRST && scan_stage <= ngte_pkg::STAGE_LAST) begin
      if (is_comma) begin
        scan_stage_next = scan_stage + ngte_pkg::STAGE_W'(1);
        if (scan_stage == ngte_pkg::STAGE_LAST) begin
          capture_count_next = '0;
        end
      end
    end else if (capturing) begin
      if (capture_count == ngte_pkg::COUNT_LAST) begin
        scan_stage_next    = ngte_pkg::STAGE_IDLE;
        capture_count_next = '0;
      end else begin
        capture_count_next = capture_count + ngte_pkg::COUNT_W'(1);
      end
    end
  end

  // Hour in UTC from the two hour bytes, 8-bit wrap
  always_comb begin
    logic [7:0] tens_val;
    tens_val  = time_digits[0] - ngte_pkg::CHAR_ZERO;
    base_next = 8'({tens_val, 3'b000}) + 8'({tens_val, 1'b0})
              + (byte_in.rx_byte - ngte_pkg::CHAR_ZERO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_stage    <= ngte_pkg::STAGE_IDLE;
      capture_count <= '0;
    end else if (accept) begin
      scan_stage    <= scan_stage_next;
      capture_count <= capture_count_next;
    end
  end

  // Hold the captured bytes and the UTC hour
  always_ff @(posedge clk) begin
    if (accept && !is_l && capturing && capture_count != ngte_pkg::COUNT_LAST) begin
      time_digits[capture_count] <= byte_in.rx_byte;
      if (capture_count == ngte_pkg::COUNT_HOUR_ONES) begin
        hour_base <= base_next;
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      hour_offset <= ngte_pkg::HOUR_OFFSET_RESET;
    end else if (cfg_wr_en) begin
      hour_offset <= cfg_wr_data;
    end
  end

  // Hour-sum stage: add the offset, latch minute and second bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (emit) begin
      mid_valid <= 1'b1;
    end else if (mid_adv) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      mid_sum      <= hour_base + 8'(hour_offset);
      mid_min_tens <= time_digits[2];
      mid_min_ones <= time_digits[3];
      mid_sec_tens <= time_digits[4];
      mid_sec_ones <= byte_in.rx_byte;
    end
  end

  // Output stage: reduce modulo 24 and present the item
  assign hour_res = ngte_pkg::hour_chars(mid_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_adv) begin
      out_valid <= 1'b1;
    end else if (time_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_adv) begin
      out_item.hour_tens_char   <= hour_res.tens;
      out_item.hour_ones_char   <= hour_res.ones;
      out_item.minute_tens_char <= mid_min_tens;
      out_item.minute_ones_char <= mid_min_ones;
      out_item.second_tens_char <= mid_sec_tens;
      out_item.second_ones_char <= mid_sec_ones;
    end
  end

endmodule

// ===== rtl/ngte_chk.sv =====
// Port-level assertions for the GLL time extractor, bound to the top level.
module ngte_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ngte_pkg::CHAR_W-1:0]   hour_tens_char,
  input logic [ngte_pkg::CHAR_W-1:0]   hour_ones_char
);

  // Hold a result item until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // Start empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item present right after reset");

  // Local hour tens digit lies in '0'..'2'
  a_hour_tens: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hour_tens_char >= ngte_pkg::CHAR_ZERO && hour_tens_char <= ngte_pkg::CHAR_TWO))
    else $error("hour tens digit out of range");

  // Local hour ones digit is a digit, at most '3' past twenty
  a_hour_ones: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hour_ones_char >= ngte_pkg::CHAR_ZERO && hour_ones_char <= ngte_pkg::CHAR_NINE
                   && (hour_tens_char != ngte_pkg::CHAR_TWO
                       || hour_ones_char <= ngte_pkg::CHAR_THREE)))
    else $error("hour ones digit out of range");

endmodule

bind nmea_gll_time_extract_local ngte_chk u_ngte_chk (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (time_out.valid),
  .out_ready      (time_out.ready),
  .hour_tens_char (time_out.item.hour_tens_char),
  .hour_ones_char (time_out.item.hour_ones_char)
);
